// File: hw/rtl/huffman_code_table_builder_macros.svh
// ----------------------------------------------------------------------------
// huffman code table builder assertion macros
// shared helpers for the concurrent checks of the block
// ----------------------------------------------------------------------------
`ifndef HUFFMAN_CODE_TABLE_BUILDER_MACROS_SVH
`define HUFFMAN_CODE_TABLE_BUILDER_MACROS_SVH

// condition implies consequence in the same cycle
`define HCTB_ASSERT_NOW(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define HCTB_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/hctb_pkg.sv
// ----------------------------------------------------------------------------
// hctb_pkg
// constants shared by the huffman code table builder
// ----------------------------------------------------------------------------
`default_nettype none

package hctb_pkg;

  localparam int MAX_SYMBOLS_DEF  = 64;
  localparam int MAX_CODE_LEN_DEF = 48;

  localparam int SYM_W      = 8;
  localparam int FREQ_W     = 24;
  localparam int WEIGHT_W   = 32;
  localparam int CODE_OUT_W = 48;
  localparam int LEN_W      = 6;
  localparam int IN_DATA_W  = 32;
  localparam int OUT_DATA_W = 64;

endpackage

`default_nettype wire

// File: hw/rtl/huffman_code_table_builder.sv
// ----------------------------------------------------------------------------
// huffman_code_table_builder
// builds a huffman code table from (symbol, frequency) items via a binary heap
// ----------------------------------------------------------------------------
// usage
//   s_* channel: one (symbol, frequency) item per cycle while s_tready is high,
//   s_tlast marks the final item of a run and starts the build. items past
//   MAX_SYMBOLS are dropped, a dropped item with s_tlast still starts the build
//   m_* channel: one item per leaf in left-first depth-first order, with the
//   code right-aligned (first branch bit most significant), its length and
//   m_tlast on the final entry. a lone symbol gets a zero-length code
//   build: the build runs in a single heap memory with one read per cycle;
//   heapify and every pop sift down the tree level by level, and every push
//   sifts up level by level. the walk visits every internal node and leaf
//   and pauses while the receiver holds m_tready low
//   s_tready is low from the last item until the final result is taken
//   reset: synchronous, clears the sequencer and counters; memories are not
//   cleared, every entry is written before it is read within a run
//   stall: a result waits in the output register and the walk pauses
// ----------------------------------------------------------------------------
`default_nettype none

module huffman_code_table_builder
  import hctb_pkg::*;
#(
  parameter int MAX_SYMBOLS  = MAX_SYMBOLS_DEF,
  parameter int MAX_CODE_LEN = MAX_CODE_LEN_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // tdata: symbol [7:0], frequency [31:8]
  input  wire logic [IN_DATA_W-1:0]  s_tdata,
  input  wire logic                  s_tvalid,
  input  wire logic                  s_tlast,
  output logic                       s_tready,
  // tdata: out_symbol [7:0], code_bits [55:8], code_length [61:56], zero [63:62]
  output logic [OUT_DATA_W-1:0]      m_tdata,
  output logic                       m_tvalid,
  output logic                       m_tlast,
  input  wire logic                  m_tready
);

  `include "huffman_code_table_builder_macros.svh"

  localparam int NODE_COUNT = 2 * MAX_SYMBOLS;
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int HEAP_W     = $clog2(MAX_SYMBOLS);
  localparam int CNT_W      = $clog2(MAX_SYMBOLS + 1);
  localparam int POS_W      = CNT_W + 1;
  localparam int SP_W       = $clog2(NODE_COUNT + 1);
  localparam int DEPTH_W    = NODE_W;
  localparam int HE_W       = NODE_W + WEIGHT_W;
  localparam int ST_W       = NODE_W + DEPTH_W + MAX_CODE_LEN;

  // sequencer states
  localparam logic [4:0] S_LOAD    = 5'd0;
  localparam logic [4:0] S_HB_INIT = 5'd1;
  localparam logic [4:0] S_HB_RD   = 5'd2;
  localparam logic [4:0] S_HB_E    = 5'd3;
  localparam logic [4:0] S_SD_CHK  = 5'd4;
  localparam logic [4:0] S_SD_L    = 5'd5;
  localparam logic [4:0] S_SD_R    = 5'd6;
  localparam logic [4:0] S_SD_DEC  = 5'd7;
  localparam logic [4:0] S_SD_RET  = 5'd8;
  localparam logic [4:0] S_P_RD0   = 5'd9;
  localparam logic [4:0] S_P_RD1   = 5'd10;
  localparam logic [4:0] S_P_E     = 5'd11;
  localparam logic [4:0] S_MG_WR   = 5'd12;
  localparam logic [4:0] S_PU_CHK  = 5'd13;
  localparam logic [4:0] S_PU_CMP  = 5'd14;
  localparam logic [4:0] S_MG_CHK  = 5'd15;
  localparam logic [4:0] S_ROOT    = 5'd16;
  localparam logic [4:0] S_W_INIT  = 5'd17;
  localparam logic [4:0] S_W_POP   = 5'd18;
  localparam logic [4:0] S_W_DEC   = 5'd19;
  localparam logic [4:0] S_W_CH    = 5'd20;
  localparam logic [4:0] S_W_CH2   = 5'd21;
  localparam logic [4:0] S_W_SYM   = 5'd22;
  localparam logic [4:0] S_W_OUT   = 5'd23;

  // best-child selection in the sift
  localparam logic [1:0] SEL_SELF  = 2'd0;
  localparam logic [1:0] SEL_LEFT  = 2'd1;
  localparam logic [1:0] SEL_RIGHT = 2'd2;

  logic [4:0]              state;
  logic [CNT_W-1:0]        loaded;
  logic [CNT_W-1:0]        hc;
  logic [HEAP_W-1:0]       pos;
  logic [HEAP_W-1:0]       hi;
  logic [HEAP_W-1:0]       pi;
  logic [HE_W-1:0]         e_ent;
  logic [HE_W-1:0]         l_ent;
  logic [HE_W-1:0]         r_ent;
  logic                    has_r;
  logic [HE_W-1:0]         top_a;
  logic [HE_W-1:0]         top_b;
  logic [HE_W-1:0]         push_ent;
  logic                    pop2;
  logic                    sift_ret;
  logic [NODE_W-1:0]       next_node;
  logic [SP_W-1:0]         sp;
  logic [NODE_W-1:0]       w_node;
  logic [DEPTH_W-1:0]      w_depth;
  logic [MAX_CODE_LEN-1:0] w_code;
  logic                    w_last;
  logic [SYM_W-1:0]        o_sym;
  logic [CODE_OUT_W-1:0]   o_code;
  logic [LEN_W-1:0]        o_len;
  logic                    o_last;
  logic                    o_valid;

  // memory ports
  logic                    hw_en;
  logic [HEAP_W-1:0]       hw_addr;
  logic [HE_W-1:0]         hw_data;
  logic [HEAP_W-1:0]       hr_addr;
  logic [HE_W-1:0]         hr_data;
  logic                    sym_we;
  logic [HEAP_W-1:0]       sym_raddr;
  logic [SYM_W-1:0]        sym_rdata;
  logic                    ch_we;
  logic [NODE_W-1:0]       ch_raddr;
  logic [2*NODE_W-1:0]     ch_wdata;
  logic [2*NODE_W-1:0]     ch_rdata;
  logic                    st_we;
  logic [NODE_W-1:0]       st_waddr;
  logic [ST_W-1:0]         st_wdata;
  logic [NODE_W-1:0]       st_raddr;
  logic [ST_W-1:0]         st_rdata;

  // decoded helpers
  logic [SYM_W-1:0]        in_sym;
  logic [FREQ_W-1:0]       in_freq;
  logic                    in_fire;
  logic                    can_store;
  logic [POS_W-1:0]        l_idx;
  logic [POS_W-1:0]        r_idx;
  logic                    l_in;
  logic                    r_in;
  logic [1:0]              bsel;
  logic [HE_W-1:0]         best_ent;
  logic [HEAP_W-1:0]       pi_parent;
  logic                    push_less;
  logic [WEIGHT_W-1:0]     merge_w;
  logic [NODE_W-1:0]       st_node;
  logic                    is_leaf;
  logic                    st_room;
  logic [DEPTH_W-1:0]      child_depth;
  logic [SP_W-1:0]         sp_plus1;
  logic [63:0]             code_wide;
  logic [LEN_W-1:0]        len_sat;

  assign in_sym    = s_tdata[SYM_W-1:0];
  assign in_freq   = s_tdata[SYM_W +: FREQ_W];
  assign s_tready  = (state == S_LOAD);
  assign in_fire   = s_tvalid && s_tready;
  assign can_store = (32'(loaded) < 32'(MAX_SYMBOLS));

  // heap children of the sift position
  assign l_idx = (POS_W'(pos) << 1) + POS_W'(1);
  assign r_idx = l_idx + POS_W'(1);
  assign l_in  = (l_idx < POS_W'(hc));
  assign r_in  = (r_idx < POS_W'(hc));

  // strict less-than, left child checked first
  always_comb begin
    logic [WEIGHT_W-1:0] bw;
    bw   = e_ent[WEIGHT_W-1:0];
    bsel = SEL_SELF;
    if (l_ent[WEIGHT_W-1:0] < bw) begin
      bsel = SEL_LEFT;
      bw   = l_ent[WEIGHT_W-1:0];
    end
    if (has_r && (r_ent[WEIGHT_W-1:0] < bw)) begin
      bsel = SEL_RIGHT;
    end
  end

  always_comb begin
    case (bsel)
      SEL_LEFT:  best_ent = l_ent;
      SEL_RIGHT: best_ent = r_ent;
      default:   best_ent = e_ent;
    endcase
  end

  assign pi_parent   = (pi - HEAP_W'(1)) >> 1;
  assign push_less   = (push_ent[WEIGHT_W-1:0] < hr_data[WEIGHT_W-1:0]);
  assign merge_w     = top_a[WEIGHT_W-1:0] + top_b[WEIGHT_W-1:0];
  assign st_node     = st_rdata[ST_W-1 -: NODE_W];
  assign is_leaf     = (32'(st_node) < 32'(loaded));
  assign st_room     = (32'(sp) + 32'd2 <= 32'(NODE_COUNT));
  assign child_depth = w_depth + DEPTH_W'(1);
  assign sp_plus1    = sp + SP_W'(1);
  assign code_wide   = 64'(w_code);
  assign len_sat     = (32'(w_depth) > 32'(MAX_CODE_LEN)) ? LEN_W'(MAX_CODE_LEN)
                                                           : LEN_W'(w_depth);

  // memory port steering
  always_comb begin
    hw_en     = 1'b0;
    hw_addr   = pos;
    hw_data   = e_ent;
    hr_addr   = '0;
    sym_we    = 1'b0;
    sym_raddr = HEAP_W'(st_node);
    ch_we     = 1'b0;
    ch_wdata  = {top_a[HE_W-1 -: NODE_W], top_b[HE_W-1 -: NODE_W]};
    ch_raddr  = st_node;
    st_we     = 1'b0;
    st_waddr  = sp[NODE_W-1:0];
    st_wdata  = {w_node, w_depth, w_code};
    st_raddr  = NODE_W'(sp - SP_W'(1));
    case (state)
      S_LOAD: begin
        if (in_fire && can_store) begin
          hw_en   = 1'b1;
          hw_addr = HEAP_W'(loaded);
          hw_data = {NODE_W'(loaded), WEIGHT_W'(in_freq)};
          sym_we  = 1'b1;
        end
      end
      S_HB_RD:  hr_addr = hi;
      S_SD_CHK: begin
        if (l_in) begin
          hr_addr = HEAP_W'(l_idx);
        end else begin
          hw_en = 1'b1;
        end
      end
      S_SD_L:   hr_addr = HEAP_W'(r_idx);
      S_SD_DEC: begin
        hw_en   = 1'b1;
        hw_data = best_ent;
      end
      S_P_RD0:  hr_addr = '0;
      S_P_RD1:  hr_addr = HEAP_W'(hc - CNT_W'(1));
      S_MG_WR:  ch_we = 1'b1;
      S_PU_CHK: begin
        if (pi == '0) begin
          hw_en   = 1'b1;
          hw_addr = '0;
          hw_data = push_ent;
        end else begin
          hr_addr = pi_parent;
        end
      end
      S_PU_CMP: begin
        hw_en   = 1'b1;
        hw_addr = pi;
        hw_data = push_less ? hr_data : push_ent;
      end
      S_ROOT:   hr_addr = '0;
      S_W_INIT: begin
        st_we    = 1'b1;
        st_waddr = '0;
        st_wdata = {hr_data[HE_W-1 -: NODE_W], {DEPTH_W{1'b0}}, {MAX_CODE_LEN{1'b0}}};
      end
      S_W_CH: begin
        // keep the children of the node being expanded on the read port
        ch_raddr = w_node;
        st_we    = 1'b1;
        st_wdata = {ch_rdata[NODE_W-1:0], child_depth, w_code[MAX_CODE_LEN-2:0], 1'b1};
      end
      S_W_CH2: begin
        ch_raddr = w_node;
        st_we    = 1'b1;
        st_waddr = sp_plus1[NODE_W-1:0];
        st_wdata = {ch_rdata[2*NODE_W-1 -: NODE_W], child_depth,
                    w_code[MAX_CODE_LEN-2:0], 1'b0};
      end
      default: ;
    endcase
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_LOAD;
      loaded   <= '0;
      hc       <= '0;
      o_valid  <= 1'b0;
      pop2     <= 1'b0;
      sift_ret <= 1'b0;
      sp       <= '0;
    end else begin
      case (state)
        S_LOAD: begin
          if (in_fire) begin
            if (can_store) begin
              loaded <= loaded + CNT_W'(1);
            end
            if (s_tlast) begin
              state <= S_HB_INIT;
            end
          end
        end
        S_HB_INIT: begin
          hc        <= loaded;
          next_node <= NODE_W'(loaded);
          hi        <= (loaded >= CNT_W'(2)) ? HEAP_W'((loaded - CNT_W'(2)) >> 1) : '0;
          state     <= S_HB_RD;
        end
        S_HB_RD: state <= S_HB_E;
        S_HB_E: begin
          e_ent    <= hr_data;
          pos      <= hi;
          sift_ret <= 1'b0;
          state    <= S_SD_CHK;
        end
        S_SD_CHK: state <= l_in ? S_SD_L : S_SD_RET;
        S_SD_L: begin
          l_ent <= hr_data;
          has_r <= 1'b0;
          state <= r_in ? S_SD_R : S_SD_DEC;
        end
        S_SD_R: begin
          r_ent <= hr_data;
          has_r <= 1'b1;
          state <= S_SD_DEC;
        end
        S_SD_DEC: begin
          case (bsel)
            SEL_LEFT: begin
              pos   <= HEAP_W'(l_idx);
              state <= S_SD_CHK;
            end
            SEL_RIGHT: begin
              pos   <= HEAP_W'(r_idx);
              state <= S_SD_CHK;
            end
            default: state <= S_SD_RET;
          endcase
        end
        S_SD_RET: begin
          if (!sift_ret) begin
            if (hi == '0) begin
              state <= S_MG_CHK;
            end else begin
              hi    <= hi - HEAP_W'(1);
              state <= S_HB_RD;
            end
          end else if (!pop2) begin
            pop2  <= 1'b1;
            state <= S_P_RD0;
          end else begin
            pop2  <= 1'b0;
            state <= S_MG_WR;
          end
        end
        S_P_RD0: state <= S_P_RD1;
        S_P_RD1: begin
          if (!pop2) begin
            top_a <= hr_data;
          end else begin
            top_b <= hr_data;
          end
          state <= S_P_E;
        end
        S_P_E: begin
          e_ent    <= hr_data;
          hc       <= hc - CNT_W'(1);
          pos      <= '0;
          sift_ret <= 1'b1;
          state    <= S_SD_CHK;
        end
        S_MG_WR: begin
          push_ent  <= {next_node, merge_w};
          pi        <= HEAP_W'(hc);
          hc        <= hc + CNT_W'(1);
          next_node <= next_node + NODE_W'(1);
          state     <= S_PU_CHK;
        end
        S_PU_CHK: state <= (pi == '0) ? S_MG_CHK : S_PU_CMP;
        S_PU_CMP: begin
          if (push_less) begin
            pi    <= pi_parent;
            state <= S_PU_CHK;
          end else begin
            state <= S_MG_CHK;
          end
        end
        S_MG_CHK: begin
          pop2  <= 1'b0;
          state <= (hc > CNT_W'(1)) ? S_P_RD0 : S_ROOT;
        end
        S_ROOT: state <= S_W_INIT;
        S_W_INIT: begin
          sp    <= SP_W'(1);
          state <= S_W_POP;
        end
        S_W_POP: begin
          sp    <= sp - SP_W'(1);
          state <= S_W_DEC;
        end
        S_W_DEC: begin
          w_node  <= st_node;
          w_depth <= st_rdata[MAX_CODE_LEN +: DEPTH_W];
          w_code  <= st_rdata[MAX_CODE_LEN-1:0];
          w_last  <= (sp == '0);
          if (is_leaf) begin
            state <= S_W_SYM;
          end else if (st_room) begin
            state <= S_W_CH;
          end else if (sp != '0) begin
            state <= S_W_POP;
          end else begin
            loaded <= '0;
            hc     <= '0;
            state  <= S_LOAD;
          end
        end
        S_W_CH:  state <= S_W_CH2;
        S_W_CH2: begin
          sp    <= sp + SP_W'(2);
          state <= S_W_POP;
        end
        S_W_SYM: begin
          o_sym   <= sym_rdata;
          o_code  <= code_wide[CODE_OUT_W-1:0];
          o_len   <= len_sat;
          o_last  <= w_last;
          o_valid <= 1'b1;
          state   <= S_W_OUT;
        end
        S_W_OUT: begin
          if (m_tready) begin
            o_valid <= 1'b0;
            if (o_last) begin
              loaded <= '0;
              hc     <= '0;
              state  <= S_LOAD;
            end else begin
              state <= S_W_POP;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end

  assign m_tvalid = o_valid;
  assign m_tlast  = o_last;
  assign m_tdata  = {2'b00, o_len, o_code, o_sym};

  // heap of (node, weight) entries
  hctb_ram #(.WIDTH(HE_W), .DEPTH(MAX_SYMBOLS)) u_heap (
    .clk   (clk),
    .we    (hw_en),
    .waddr (hw_addr),
    .wdata (hw_data),
    .raddr (hr_addr),
    .rdata (hr_data)
  );

  // leaf symbols by load order
  hctb_ram #(.WIDTH(SYM_W), .DEPTH(MAX_SYMBOLS)) u_sym (
    .clk   (clk),
    .we    (sym_we),
    .waddr (HEAP_W'(loaded)),
    .wdata (in_sym),
    .raddr (sym_raddr),
    .rdata (sym_rdata)
  );

  // children of merged nodes, {left, right}
  hctb_ram #(.WIDTH(2*NODE_W), .DEPTH(NODE_COUNT)) u_child (
    .clk   (clk),
    .we    (ch_we),
    .waddr (next_node),
    .wdata (ch_wdata),
    .raddr (ch_raddr),
    .rdata (ch_rdata)
  );

  // walk stack, {node, depth, code}
  hctb_ram #(.WIDTH(ST_W), .DEPTH(NODE_COUNT)) u_stack (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (st_wdata),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // checks
  `HCTB_ASSERT_NOW(a_no_overlap, s_tready, !m_tvalid, "load and emission overlap")
  `HCTB_ASSERT_NOW(a_heap_bound, 1'b1, hc <= loaded, "heap larger than loaded set")
  `HCTB_ASSERT_NOW(a_stack_bound, 1'b1, 32'(sp) <= 32'(NODE_COUNT), "walk stack overflow")
  `HCTB_ASSERT_NEXT(a_rearm, m_tvalid && m_tready && m_tlast, s_tready && loaded == '0,
                    "block not rearmed after final entry")

endmodule

`default_nettype wire

// File: hw/rtl/hctb_ram.sv
// ----------------------------------------------------------------------------
// hctb_ram
// simple dual port memory, one write and one registered read per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module hctb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire
